// ===== rtl/qdl2_pkg.sv =====
// Package for the quantized dot product / L2 distance block.
// Holds request/response types, the lane-tree node type and the shared
// element, clamp and node-composition functions. No dependencies.
package qdl2_pkg;

    // Lane and tree geometry
    localparam int LANES      = 4;
    localparam int LEVELS     = $clog2(LANES);
    localparam int LEAVES     = 1 << LEVELS;

    // Field widths
    localparam int ELEM_W     = 32;
    localparam int PROD_W     = 2 * ELEM_W;
    localparam int ACC_W      = 64;
    localparam int NORM_W     = 63;
    localparam int LANE_CNT_W = 3;
    localparam int CFG_DATA_W = 2;

    // Tree sums grow by one bit per level, plus headroom for a bound added to them
    localparam int SUM_W      = ACC_W + LEVELS + 1;
    // Norm sum minus twice the inner product
    localparam int COMB_W     = ACC_W + 2;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef enum logic [1:0] {
        W_INT8  = 2'd0,
        W_INT16 = 2'd1,
        W_INT32 = 2'd2
    } t_qdl2_width;

    typedef enum logic [0:0] {
        CFG_ELEM_WIDTH  = 1'b0,
        CFG_METRIC_MODE = 1'b1
    } t_qdl2_cfg_idx;

    typedef struct packed {
        logic signed [ELEM_W-1:0] query_elem_0;
        logic signed [ELEM_W-1:0] query_elem_1;
        logic signed [ELEM_W-1:0] query_elem_2;
        logic signed [ELEM_W-1:0] query_elem_3;
        logic signed [ELEM_W-1:0] entry_elem_0;
        logic signed [ELEM_W-1:0] entry_elem_1;
        logic signed [ELEM_W-1:0] entry_elem_2;
        logic signed [ELEM_W-1:0] entry_elem_3;
        logic [LANE_CNT_W-1:0]    lane_count;
        logic [NORM_W-1:0]        query_norm;
        logic [NORM_W-1:0]        entry_norm;
        logic                     last_item;
    } t_qdl2_req;

    typedef struct packed {
        logic signed [ACC_W-1:0] distance;
        logic                    saturated;
    } t_qdl2_rsp;

    // Control that travels beside the lane data through the pipeline
    typedef struct packed {
        logic              vld;
        logic              last;
        logic [NORM_W-1:0] query_norm;
        logic [NORM_W-1:0] entry_norm;
    } t_qdl2_side;

    // A run of saturating adds written as x -> clamp(x + sum, lo, hi).
    // pmin/pmax are the extreme prefix sums (including the empty prefix);
    // a start value x saturates somewhere iff x + pmin < MIN or x + pmax > MAX.
    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic signed [ACC_W-1:0] lo;
        logic signed [ACC_W-1:0] hi;
        logic signed [SUM_W-1:0] pmin;
        logic signed [SUM_W-1:0] pmax;
    } t_qdl2_node;

    // Sign-extend the low 8, 16 or 32 bits; the unused code acts as int32
    function automatic logic signed [ELEM_W-1:0] widen(
        input logic [ELEM_W-1:0] raw,
        input logic [1:0]        code
    );
        logic signed [ELEM_W-1:0] v;
        case (code)
            W_INT8:  v = {{(ELEM_W-8){raw[7]}}, raw[7:0]};
            W_INT16: v = {{(ELEM_W-16){raw[15]}}, raw[15:0]};
            default: v = raw;
        endcase
        return v;
    endfunction

    // Clamp a wide value into [lo, hi], both inside the accumulator range
    function automatic logic signed [ACC_W-1:0] clamp_acc(
        input logic signed [SUM_W-1:0] v,
        input logic signed [ACC_W-1:0] lo,
        input logic signed [ACC_W-1:0] hi
    );
        logic signed [SUM_W-1:0] lo_x;
        logic signed [SUM_W-1:0] hi_x;
        logic signed [ACC_W-1:0] res;
        lo_x = SUM_W'(lo);
        hi_x = SUM_W'(hi);
        if (v < lo_x) begin
            res = lo;
        end else if (v > hi_x) begin
            res = hi;
        end else begin
            res = v[ACC_W-1:0];
        end
        return res;
    endfunction

    function automatic t_qdl2_node node_ident();
        t_qdl2_node res;
        res.sum  = '0;
        res.lo   = ACC_MIN;
        res.hi   = ACC_MAX;
        res.pmin = '0;
        res.pmax = '0;
        return res;
    endfunction

    // One saturating add of a lane product, or nothing for an idle lane
    function automatic t_qdl2_node node_leaf(
        input logic signed [PROD_W-1:0] p,
        input logic                     on
    );
        t_qdl2_node res;
        res = node_ident();
        if (on) begin
            res.sum  = SUM_W'(p);
            res.pmin = (p < 0) ? SUM_W'(p) : '0;
            res.pmax = (p > 0) ? SUM_W'(p) : '0;
        end
        return res;
    endfunction

    // Apply run f first, then run g
    function automatic t_qdl2_node node_join(
        input t_qdl2_node f,
        input t_qdl2_node g
    );
        t_qdl2_node              res;
        logic signed [SUM_W-1:0] lo_s;
        logic signed [SUM_W-1:0] hi_s;
        logic signed [SUM_W-1:0] mn_s;
        logic signed [SUM_W-1:0] mx_s;
        res.sum  = f.sum + g.sum;
        lo_s     = SUM_W'(f.lo) + g.sum;
        hi_s     = SUM_W'(f.hi) + g.sum;
        res.lo   = clamp_acc(lo_s, g.lo, g.hi);
        res.hi   = clamp_acc(hi_s, g.lo, g.hi);
        mn_s     = f.sum + g.pmin;
        mx_s     = f.sum + g.pmax;
        res.pmin = (mn_s < f.pmin) ? mn_s : f.pmin;
        res.pmax = (mx_s > f.pmax) ? mx_s : f.pmax;
        return res;
    endfunction

endpackage

// ===== rtl/qdl2_req_if.sv =====
// Request channel of the dot product block: valid/ready plus one item.
// Depends on qdl2_pkg for the payload type.
interface qdl2_req_if;
    import qdl2_pkg::*;

    logic      valid;
    logic      ready;
    t_qdl2_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/qdl2_rsp_if.sv =====
// Response channel of the dot product block: valid/ready plus one result.
// Depends on qdl2_pkg for the payload type.
interface qdl2_rsp_if;
    import qdl2_pkg::*;

    logic      valid;
    logic      ready;
    t_qdl2_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/quantized_dot_product_l2.sv =====
// Top level of the streaming signed dot product / squared L2 distance block.
// Depends on qdl2_pkg, qdl2_req_if, qdl2_rsp_if, qdl2_lane, qdl2_merge, qdl2_accum.
//
// Usage:
//   i_req carries one request per cycle when ready: four query/entry element pairs,
//   a lane count (lowest lanes first, values above four act as four), the
//   two squared norms and a last flag. o_rsp returns one result per vector
//   pair, on the request marked last: the inner product, or with metric
//   mode set, query norm + entry norm - 2 * inner product, saturated to
//   64 bits with a flag that also records accumulator saturation.
//   The configuration port (i_cfg_we, i_cfg_idx, i_cfg_data) sets the
//   element width and the metric mode; write it while no pair is in flight.
// Throughput: one request per cycle while the skid register is free; four lanes
//   multiply in parallel and a two-level registered tree merges them, so the
//   accumulator sees one merged item per cycle.
// Result path: the last request passes the lane register, then two tree levels,
//   the accumulator register and the output register before it reaches o_rsp.
// Reset: synchronous, clears the running sum, the pipeline valids and the
//   output buffer; element width returns to int32 and mode to inner product.
// Stall: the output register and a skid register absorb results while
//   o_rsp.ready is low; i_req.ready drops only once the skid register fills.
module quantized_dot_product_l2 (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    qdl2_req_if.sink                          i_req,
    qdl2_rsp_if.source                        o_rsp,
    input  logic                              i_cfg_we,
    input  qdl2_pkg::t_qdl2_cfg_idx           i_cfg_idx,
    input  logic [qdl2_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import qdl2_pkg::*;

    logic [1:0]         r_elem_width;
    logic               r_metric_mode;
    logic               w_en;
    logic [ELEM_W-1:0]  w_query [LANES];
    logic [ELEM_W-1:0]  w_entry [LANES];
    logic               w_lane_on [LANES];
    t_qdl2_node         w_leaf [LANES];
    t_qdl2_side         r_side0;
    t_qdl2_node         w_root;
    t_qdl2_side         w_root_side;
    t_qdl2_rsp          w_res;
    logic               w_res_vld;

    t_qdl2_rsp          r_out;
    t_qdl2_rsp          n_out;
    logic               r_out_vld;
    logic               n_out_vld;
    t_qdl2_rsp          r_skid;
    t_qdl2_rsp          n_skid;
    logic               r_skid_vld;
    logic               n_skid_vld;
    logic               w_out_take;
    logic               w_new;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elem_width  <= W_INT32;
            r_metric_mode <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ELEM_WIDTH:  r_elem_width  <= i_cfg_data[1:0];
                CFG_METRIC_MODE: r_metric_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // The whole pipeline advances while the skid register is free
    assign w_en        = !r_skid_vld;
    assign i_req.ready = w_en;

    // Unpack the request into lanes
    assign w_query[0] = i_req.payload.query_elem_0;
    assign w_query[1] = i_req.payload.query_elem_1;
    assign w_query[2] = i_req.payload.query_elem_2;
    assign w_query[3] = i_req.payload.query_elem_3;
    assign w_entry[0] = i_req.payload.entry_elem_0;
    assign w_entry[1] = i_req.payload.entry_elem_1;
    assign w_entry[2] = i_req.payload.entry_elem_2;
    assign w_entry[3] = i_req.payload.entry_elem_3;

    for (genvar i = 0; i < LANES; i++) begin : g_lane
        assign w_lane_on[i] = (i < int'(i_req.payload.lane_count));

        qdl2_lane u_lane (
            .i_clk        (i_clk),
            .i_en         (w_en),
            .i_lane_on    (w_lane_on[i]),
            .i_elem_width (r_elem_width),
            .i_query      (w_query[i]),
            .i_entry      (w_entry[i]),
            .o_leaf       (w_leaf[i])
        );
    end

    // Side band next to the lane registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side0.vld <= 1'b0;
        end else if (w_en) begin
            r_side0.vld        <= i_req.valid;
            r_side0.last       <= i_req.payload.last_item;
            r_side0.query_norm <= i_req.payload.query_norm;
            r_side0.entry_norm <= i_req.payload.entry_norm;
        end
    end

    qdl2_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_leaf  (w_leaf),
        .i_side  (r_side0),
        .o_root  (w_root),
        .o_side  (w_root_side)
    );

    qdl2_accum u_accum (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_en),
        .i_metric_mode (r_metric_mode),
        .i_root        (w_root),
        .i_side        (w_root_side),
        .o_res         (w_res),
        .o_res_vld     (w_res_vld)
    );

    // Output register with skid: drain the skid first, else park new results
    assign w_out_take = r_out_vld && o_rsp.ready;
    assign w_new      = w_en && w_res_vld;

    always_comb begin
        n_out      = r_out;
        n_out_vld  = r_out_vld;
        n_skid     = r_skid;
        n_skid_vld = r_skid_vld;
        if (r_skid_vld) begin
            if (w_out_take) begin
                n_out      = r_skid;
                n_skid_vld = 1'b0;
            end
        end else if (w_new) begin
            if (!r_out_vld || w_out_take) begin
                n_out     = w_res;
                n_out_vld = 1'b1;
            end else begin
                n_skid     = w_res;
                n_skid_vld = 1'b1;
            end
        end else if (w_out_take) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_rsp.valid   = r_out_vld;
    assign o_rsp.payload = r_out;

    // The skid only fills behind a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid holds a result while output register is empty");

    // The skid fills only when the receiver stalled a waiting result
    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_vld) |-> $past(r_out_vld && !o_rsp.ready))
        else $error("skid filled without a stall");

    // A drained skid moves into the output register in order
    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_vld && o_rsp.ready) |=> (r_out == $past(r_skid)) && !r_skid_vld)
        else $error("skid result lost or reordered");
endmodule

// ===== rtl/qdl2_lane.sv =====
// One multiply lane: widens an element pair, multiplies it and registers
// the product as a leaf of the merge tree. Depends on qdl2_pkg.
module qdl2_lane (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic                          i_lane_on,
    input  logic [1:0]                    i_elem_width,
    input  logic [qdl2_pkg::ELEM_W-1:0]   i_query,
    input  logic [qdl2_pkg::ELEM_W-1:0]   i_entry,
    output qdl2_pkg::t_qdl2_node          o_leaf
);
    import qdl2_pkg::*;

    logic signed [ELEM_W-1:0] w_query;
    logic signed [ELEM_W-1:0] w_entry;
    logic signed [PROD_W-1:0] w_prod;
    t_qdl2_node               r_leaf;

    // Widen both elements and multiply
    assign w_query = widen(i_query, i_elem_width);
    assign w_entry = widen(i_entry, i_elem_width);
    assign w_prod  = w_query * w_entry;

    // Register the leaf; an idle lane leaves the sum untouched
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_leaf <= node_leaf(w_prod, i_lane_on);
        end
    end

    assign o_leaf = r_leaf;
endmodule

// ===== rtl/qdl2_merge.sv =====
// Registered binary tree that folds the lane leaves, in lane order, into
// one saturating-add run. Depends on qdl2_pkg.
module qdl2_merge (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  qdl2_pkg::t_qdl2_node  i_leaf [qdl2_pkg::LANES],
    input  qdl2_pkg::t_qdl2_side  i_side,
    output qdl2_pkg::t_qdl2_node  o_root,
    output qdl2_pkg::t_qdl2_side  o_side
);
    import qdl2_pkg::*;

    // Heap order: node i has children 2i and 2i+1, leaves sit at LEAVES..2*LEAVES-1
    t_qdl2_node w_node [1:2*LEAVES-1];
    t_qdl2_side w_side [0:LEVELS];

    // Pad unused leaves with the identity run
    for (genvar j = 0; j < LEAVES; j++) begin : g_leaf
        if (j < LANES) begin : g_used
            assign w_node[LEAVES+j] = i_leaf[j];
        end else begin : g_pad
            assign w_node[LEAVES+j] = node_ident();
        end
    end

    // Compose children into each inner node, one register per level
    if (LEAVES > 1) begin : g_tree
        t_qdl2_node r_node [1:LEAVES-1];
        for (genvar i = 1; i < LEAVES; i++) begin : g_inner
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_node[i] <= node_join(w_node[2*i], w_node[2*i+1]);
                end
            end
            assign w_node[i] = r_node[i];
        end
    end

    // Delay the side band by the tree depth
    assign w_side[0] = i_side;
    for (genvar k = 1; k <= LEVELS; k++) begin : g_side
        t_qdl2_side r_side;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side.vld <= 1'b0;
            end else if (i_en) begin
                r_side <= w_side[k-1];
            end
        end
        assign w_side[k] = r_side;
    end

    assign o_root = w_node[1];
    assign o_side = w_side[LEVELS];
endmodule

// ===== rtl/qdl2_accum.sv =====
// Saturating accumulator and final combination stage. Applies each item's
// merged run to the running sum and forms the inner product or L2 value.
// Depends on qdl2_pkg.
module qdl2_accum (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_metric_mode,
    input  qdl2_pkg::t_qdl2_node  i_root,
    input  qdl2_pkg::t_qdl2_side  i_side,
    output qdl2_pkg::t_qdl2_rsp   o_res,
    output logic                  o_res_vld
);
    import qdl2_pkg::*;

    localparam logic signed [SUM_W-1:0]  MAX_X = SUM_W'(ACC_MAX);
    localparam logic signed [SUM_W-1:0]  MIN_X = SUM_W'(ACC_MIN);
    localparam logic signed [COMB_W-1:0] MAX_C = COMB_W'(ACC_MAX);
    localparam logic signed [COMB_W-1:0] MIN_C = COMB_W'(ACC_MIN);

    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_ovf;
    logic                     r_res_vld;
    logic signed [ACC_W-1:0]  r_ip;
    logic                     r_sat;
    logic [NORM_W-1:0]        r_qnorm;
    logic [NORM_W-1:0]        r_enorm;

    logic signed [SUM_W-1:0]  w_acc_x;
    logic signed [SUM_W-1:0]  w_sum_x;
    logic signed [SUM_W-1:0]  w_low_x;
    logic signed [SUM_W-1:0]  w_high_x;
    logic signed [ACC_W-1:0]  n_acc;
    logic                     w_step_ovf;
    logic                     n_ovf;
    logic                     w_take;
    logic                     w_close;

    // Apply the item's run to the running sum
    always_comb begin
        w_acc_x    = SUM_W'(r_acc);
        w_sum_x    = w_acc_x + i_root.sum;
        n_acc      = clamp_acc(w_sum_x, i_root.lo, i_root.hi);
        w_low_x    = w_acc_x + i_root.pmin;
        w_high_x   = w_acc_x + i_root.pmax;
        w_step_ovf = (w_low_x < MIN_X) || (w_high_x > MAX_X);
        n_ovf      = r_ovf | w_step_ovf;
    end

    assign w_take  = i_en && i_side.vld;
    assign w_close = w_take && i_side.last;

    // Hold the running sum; clear it when the vector pair closes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_ovf <= 1'b0;
        end else if (w_close) begin
            r_acc <= '0;
            r_ovf <= 1'b0;
        end else if (w_take) begin
            r_acc <= n_acc;
            r_ovf <= n_ovf;
        end
    end

    // Capture the closing inner product and norms
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
        end else if (i_en) begin
            r_res_vld <= w_close;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_close) begin
            r_ip    <= n_acc;
            r_sat   <= n_ovf;
            r_qnorm <= i_side.query_norm;
            r_enorm <= i_side.entry_norm;
        end
    end

    // Form qn + en - 2*ip exactly and clamp it in metric mode; else pass the inner product
    logic signed [COMB_W-1:0] w_qn_x;
    logic signed [COMB_W-1:0] w_en_x;
    logic signed [COMB_W-1:0] w_ip_x;
    logic signed [COMB_W-1:0] w_l2;

    always_comb begin
        w_qn_x = {{(COMB_W-NORM_W){1'b0}}, r_qnorm};
        w_en_x = {{(COMB_W-NORM_W){1'b0}}, r_enorm};
        w_ip_x = COMB_W'(r_ip);
        w_l2   = w_qn_x + w_en_x - (w_ip_x <<< 1);
        o_res.distance  = r_ip;
        o_res.saturated = r_sat;
        if (i_metric_mode) begin
            if (w_l2 > MAX_C) begin
                o_res.distance  = ACC_MAX;
                o_res.saturated = 1'b1;
            end else if (w_l2 < MIN_C) begin
                o_res.distance  = ACC_MIN;
                o_res.saturated = 1'b1;
            end else begin
                o_res.distance  = w_l2[ACC_W-1:0];
            end
        end
    end

    assign o_res_vld = r_res_vld;

    // A closed pair leaves a clean accumulator
    a_clear_on_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_close |=> (r_acc == '0) && !r_ovf)
        else $error("accumulator not cleared after last item");

    // A result only follows a last item
    a_res_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_res_vld) |-> $past(w_close))
        else $error("result without a last item");

    // The overflow flag is sticky within a pair
    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovf && !w_close) |=> r_ovf)
        else $error("overflow flag dropped inside a vector pair");
endmodule
